// ===== sv/nqpt_pkg.sv =====
// Package for the queue pair tracker: queue geometry, opcode and register
// codes, and the request and response word types. No dependencies.
`default_nettype none

package nqpt_pkg;

    localparam int SQ_DEPTH = 64;
    localparam int CQ_DEPTH = 256;
    localparam int SQ_PTR_W = $clog2(SQ_DEPTH);
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);

    localparam logic [SQ_PTR_W-1:0] SQ_LAST_RESET = SQ_PTR_W'(SQ_DEPTH - 1);
    localparam logic [CQ_PTR_W-1:0] CQ_LAST_RESET = CQ_PTR_W'(CQ_DEPTH - 1);

    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 1;

    localparam int SLOT_SHIFT = 16;
    localparam int PHASE_BIT  = 0;

    localparam logic OP_SUBMIT   = 1'b0;
    localparam logic OP_COMPLETE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SQ_LAST_INDEX = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CQ_LAST_INDEX = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [31:0] command_word0;
        logic [15:0] completion_status;
        logic [5:0]  completion_sq_head;
    } nqpt_req_t;

    typedef struct packed {
        logic        accepted;
        logic        queue_full;
        logic [5:0]  sq_slot;
        logic [31:0] command_word0_out;
        logic [5:0]  sq_doorbell;
        logic [7:0]  cq_doorbell;
        logic        completion_error;
        logic [7:0]  status_code;
        logic [2:0]  status_type;
    } nqpt_rsp_t;

endpackage

`default_nettype wire

// ===== sv/nqpt_in_if.sv =====
// Request channel of the queue pair tracker: valid, ready and one request word.
// Depends on nqpt_pkg for the request type.
`default_nettype none

interface nqpt_in_if
    import nqpt_pkg::*;
;
    logic      valid;
    logic      ready;
    nqpt_req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/nqpt_out_if.sv =====
// Response channel of the queue pair tracker: valid, ready and one result word.
// Depends on nqpt_pkg for the response type.
`default_nettype none

interface nqpt_out_if
    import nqpt_pkg::*;
;
    logic      valid;
    logic      ready;
    nqpt_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/nvme_queue_pair_tracker_core.sv =====
// Top level of the queue pair tracker: input stage, pointer bookkeeping and
// result stage. Depends on nqpt_pkg, nqpt_in_if and nqpt_out_if.
//
// Usage: the host pushes request words on the req channel. A submit word
// (opcode OP_SUBMIT) carries command dword 0; the block answers with the
// slot, the dword tagged with the slot at bit 16 and the new tail doorbell,
// or with queue_full when the submission queue has no free entry. A
// completion word (opcode OP_COMPLETE) carries an entry's status and
// reported submission head; it is consumed only when its phase tag matches
// the expected phase, and then the completion head doorbell and the decoded
// status come back. Every request word yields exactly one result word on rsp.
// The word lands in the input register at its accepting edge and its result
// is loaded into the result register once that register is free, from which
// rsp is driven until the receiver takes it.
// Throughput is one word per cycle while the receiver keeps up; the pointer
// update, wrap compare and phase flip all sit in the combinational logic
// between the two registers, so back-to-back words see the state left by
// their predecessor. When the receiver stalls, the result register holds and
// the input register fills, after which req.ready drops.
// Reset empties both stages, zeroes the pointers, sets the expected phase to
// one and restores both last-index registers to their full-depth values.
// Configuration writes are taken in any cycle but should only be issued
// while no word is in flight.
`default_nettype none

module nvme_queue_pair_tracker_core
    import nqpt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    nqpt_in_if.sink                    req,
    nqpt_out_if.source                 rsp
);

    // Configuration registers.
    logic [SQ_PTR_W-1:0] sq_last_reg;
    logic [CQ_PTR_W-1:0] cq_last_reg;

    // Queue state.
    logic [SQ_PTR_W-1:0] sq_tail_reg, sq_tail_next;
    logic [SQ_PTR_W-1:0] sq_head_reg, sq_head_next;
    logic [CQ_PTR_W-1:0] cq_head_reg, cq_head_next;
    logic                phase_reg, phase_next;

    // Pipeline stages.
    logic      in_valid_reg;
    nqpt_req_t in_data_reg;
    logic      out_valid_reg;
    nqpt_rsp_t out_data_reg, out_data_next;

    logic out_load;
    logic in_load;

    // The result register can take a new word when it is empty or being
    // drained this cycle; the input register advances whenever it does.
    assign out_load  = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || out_load;
    assign in_load   = req.valid && req.ready;

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_last_reg <= SQ_LAST_RESET;
            cq_last_reg <= CQ_LAST_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_SQ_LAST_INDEX: sq_last_reg <= cfg_data[SQ_PTR_W-1:0];
                REG_CQ_LAST_INDEX: cq_last_reg <= cfg_data[CQ_PTR_W-1:0];
                default:           ;
            endcase
        end
    end

    // Pointer advance with wrap after the last index. A pointer left above
    // a lowered last index wraps to zero on its next advance.
    logic [SQ_PTR_W-1:0] sq_adv;
    logic [CQ_PTR_W-1:0] cq_adv;
    logic                sq_full;
    logic                phase_match;
    logic [7:0]          code;

    always_comb
    begin
        sq_adv = (sq_tail_reg >= sq_last_reg) ? '0 : sq_tail_reg + 1'b1;
        cq_adv = (cq_head_reg >= cq_last_reg) ? '0 : cq_head_reg + 1'b1;
        sq_full     = (sq_adv == sq_head_reg);
        phase_match = (in_data_reg.completion_status[PHASE_BIT] == phase_reg);
        code        = in_data_reg.completion_status[8:1];

        sq_tail_next  = sq_tail_reg;
        sq_head_next  = sq_head_reg;
        cq_head_next  = cq_head_reg;
        phase_next    = phase_reg;
        out_data_next = '0;

        case (in_data_reg.opcode)
            OP_SUBMIT:
            begin
                if (sq_full)
                begin
                    out_data_next.queue_full = 1'b1;
                end
                else
                begin
                    out_data_next.accepted          = 1'b1;
                    out_data_next.sq_slot           = sq_tail_reg;
                    out_data_next.command_word0_out = in_data_reg.command_word0 |
                        (32'(sq_tail_reg) << SLOT_SHIFT);
                    out_data_next.sq_doorbell       = sq_adv;
                    sq_tail_next                    = sq_adv;
                end
            end
            default:
            begin
                if (phase_match)
                begin
                    // The head only moves backward on a wrap, which flips
                    // the phase the device will write next.
                    if (cq_adv < cq_head_reg)
                    begin
                        phase_next = !phase_reg;
                    end
                    cq_head_next                   = cq_adv;
                    sq_head_next                   = in_data_reg.completion_sq_head;
                    out_data_next.accepted         = 1'b1;
                    out_data_next.cq_doorbell      = cq_adv;
                    out_data_next.completion_error = |code;
                    out_data_next.status_code      = code;
                    out_data_next.status_type      = in_data_reg.completion_status[11:9];
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_tail_reg   <= '0;
            sq_head_reg   <= '0;
            cq_head_reg   <= '0;
            phase_reg     <= 1'b1;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                sq_tail_reg <= sq_tail_next;
                sq_head_reg <= sq_head_next;
                cq_head_reg <= cq_head_next;
                phase_reg   <= phase_next;
            end

            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_data_reg <= req.data;
        end
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire
